[rtl/core/bmq_pkg.sv]
// Shared types and constants for the bounded max queue.
`default_nettype none
package bmq_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 6;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_MAX   = 2'd2,
    REQ_DRAIN = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic shift;
  } fifo_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } max_ctl_t;

endpackage
`default_nettype wire

[rtl/core/bounded_max_queue.sv]
// Top level: bounded FIFO with running maximum, built from chains of cells.
// A dequeue, max or refused request's result reaches the output register in the cycle
// after its word is accepted. Enqueue, dequeue and max requests can be accepted back
// to back while the output is taken. A drain clears the deque, then streams one word
// per cycle from the FIFO head cell as the chain shifts, while the output is taken.
// Reset: element count, drain flag, deque and output valid clear; capacity returns to 32.
`default_nettype none
module bounded_max_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration: queue_capacity
  input  wire logic                          cfg_we,
  input  wire logic [bmq_pkg::CAP_W-1:0]     cfg_wdata,
  // request stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [bmq_pkg::DATA_W-1:0]    s_tdata,   // [31:0] push_value
  input  wire logic [1:0]                    s_tuser,   // [1:0] req_type
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [bmq_pkg::DATA_W-1:0]         m_tdata,   // [31:0] result_data
  output logic [1:0]                         m_tuser,   // [1:0] result_status
  output logic                               m_tlast    // last_of_run
);
  import bmq_pkg::*;

  // Configuration and control state
  logic [CAP_W-1:0] queue_capacity;
  logic [CNT_W-1:0] fifo_count;
  logic             draining;

  // Cell chains
  logic signed [DATA_W-1:0] fifo_val [DEPTH];
  logic signed [DATA_W-1:0] max_val  [DEPTH];
  logic                     max_valid[DEPTH];
  logic                     max_keep [DEPTH];
  fifo_ctl_t                fifo_ctl [DEPTH];
  max_ctl_t                 max_ctl;

  // Next-state signals
  logic [CNT_W-1:0] fifo_count_next;
  logic             draining_next;
  logic             m_tvalid_next;
  logic [DATA_W-1:0] m_tdata_next;
  logic [1:0]       m_tuser_next;
  logic             m_tlast_next;
  logic             fifo_enq;
  logic             fifo_shift;

  logic             out_free;
  logic             accept;
  logic             is_empty;
  logic             is_full;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  req_t             req;

  assign req      = req_t'(s_tuser);
  assign out_free = !m_tvalid || m_tready;
  // Hold off requests while a drain streams out or the output slot is occupied and not taken.
  assign s_tready = !draining && out_free;
  assign accept   = s_tvalid && s_tready;
  assign is_empty = (fifo_count == '0);

  // Capacity above the store depth acts as the depth.
  assign cap_ext = CMP_W'(queue_capacity);
  assign cap_eff = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign is_full = (CMP_W'(fifo_count) >= cap_eff);

  always_comb begin
    fifo_count_next = fifo_count;
    draining_next   = draining;
    m_tvalid_next   = out_free ? 1'b0 : m_tvalid;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    m_tlast_next    = m_tlast;
    fifo_enq        = 1'b0;
    fifo_shift      = 1'b0;
    max_ctl         = '0;

    if (draining) begin
      // Stream one element per free output slot; the last one ends the run.
      if (out_free) begin
        fifo_shift      = 1'b1;
        fifo_count_next = fifo_count - CNT_W'(1);
        m_tvalid_next   = 1'b1;
        m_tdata_next    = fifo_val[0];
        m_tuser_next    = ST_OK;
        m_tlast_next    = (fifo_count == CNT_W'(1));
        if (fifo_count == CNT_W'(1)) begin
          draining_next = 1'b0;
        end
      end
    end else if (accept) begin
      if (req == REQ_ENQ) begin
        if (is_full) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = '0;
          m_tuser_next  = ST_FULL;
          m_tlast_next  = 1'b1;
        end else begin
          fifo_enq        = 1'b1;
          fifo_count_next = fifo_count + CNT_W'(1);
          max_ctl.push    = 1'b1;
        end
      end else if (is_empty) begin
        m_tvalid_next = 1'b1;
        m_tdata_next  = '0;
        m_tuser_next  = ST_EMPTY;
        m_tlast_next  = 1'b1;
      end else begin
        case (req)
          REQ_DEQ: begin
            fifo_shift      = 1'b1;
            fifo_count_next = fifo_count - CNT_W'(1);
            // Drop the deque front when the departing element is the maximum.
            max_ctl.pop     = max_valid[0] && (max_val[0] == fifo_val[0]);
            m_tvalid_next   = 1'b1;
            m_tdata_next    = fifo_val[0];
            m_tuser_next    = ST_OK;
            m_tlast_next    = 1'b1;
          end
          REQ_MAX: begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = max_valid[0] ? max_val[0] : '0;
            m_tuser_next  = ST_OK;
            m_tlast_next  = 1'b1;
          end
          default: begin
            // Drain: clear the deque now, stream the FIFO from next cycle.
            max_ctl.clear = 1'b1;
            draining_next = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_capacity <= CAP_RESET;
      fifo_count     <= '0;
      draining       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        queue_capacity <= cfg_wdata;
      end
      fifo_count <= fifo_count_next;
      draining   <= draining_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
    m_tlast <= m_tlast_next;
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] fifo_next_val;
      logic signed [DATA_W-1:0] max_next_val;
      logic                     max_next_valid;
      logic                     prev_keep;

      if (i == DEPTH - 1) begin : g_tail
        assign fifo_next_val  = '0;
        assign max_next_val   = '0;
        assign max_next_valid = 1'b0;
      end else begin : g_body
        assign fifo_next_val  = fifo_val[i+1];
        assign max_next_val   = max_val[i+1];
        assign max_next_valid = max_valid[i+1];
      end

      if (i == 0) begin : g_head
        assign prev_keep = 1'b1;
      end else begin : g_link
        assign prev_keep = max_keep[i-1];
      end

      // Enqueue lands in the slot just past the current occupancy.
      assign fifo_ctl[i].load  = fifo_enq && (fifo_count == CNT_W'(i));
      assign fifo_ctl[i].shift = fifo_shift;

      bmq_fifo_cell u_fifo_cell (
        .clk        (clk),
        .ctl        (fifo_ctl[i]),
        .push_value (s_tdata),
        .shift_in   (fifo_next_val),
        .value      (fifo_val[i])
      );

      bmq_max_cell u_max_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (max_ctl),
        .push_value (s_tdata),
        .prev_keep  (prev_keep),
        .next_value (max_next_val),
        .next_valid (max_next_valid),
        .value      (max_val[i]),
        .valid      (max_valid[i]),
        .keep       (max_keep[i])
      );
    end
  endgenerate

endmodule
`default_nettype wire

[rtl/core/bmq_fifo_cell.sv]
// One slot of the shifting FIFO chain.
`default_nettype none
module bmq_fifo_cell (
  input  wire logic                              clk,
  input  wire bmq_pkg::fifo_ctl_t                ctl,
  input  wire logic signed [bmq_pkg::DATA_W-1:0] push_value,
  input  wire logic signed [bmq_pkg::DATA_W-1:0] shift_in,
  output logic signed [bmq_pkg::DATA_W-1:0]      value
);
  import bmq_pkg::*;

  // Shift toward the head; load the tail slot on enqueue.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= shift_in;
    end else if (ctl.load) begin
      value <= push_value;
    end
  end

endmodule
`default_nettype wire

[rtl/core/bmq_max_cell.sv]
// One slot of the monotonic non-increasing deque chain.
`default_nettype none
module bmq_max_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bmq_pkg::max_ctl_t                 ctl,
  input  wire logic signed [bmq_pkg::DATA_W-1:0] push_value,
  input  wire logic                              prev_keep,
  input  wire logic signed [bmq_pkg::DATA_W-1:0] next_value,
  input  wire logic                              next_valid,
  output logic signed [bmq_pkg::DATA_W-1:0]      value,
  output logic                                   valid,
  output logic                                   keep
);
  import bmq_pkg::*;

  logic take;

  // Keep entries not smaller than the new value; kept entries form a prefix.
  assign keep = valid && !(value < push_value);
  assign take = !keep && prev_keep;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.push) begin
      valid <= keep || prev_keep;
    end else if (ctl.pop) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && take) begin
      value <= push_value;
    end else if (ctl.pop) begin
      value <= next_value;
    end
  end

endmodule
`default_nettype wire

[rtl/core/bmq_checker.sv]
// Port-level checks for the bounded max queue, bound to the top level.
`default_nettype none
module bmq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic [1:0]                 s_tuser,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [bmq_pkg::DATA_W-1:0] m_tdata,
  input wire logic [1:0]                 m_tuser,
  input wire logic                       m_tlast
);
  import bmq_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result word changed while stalled");

  // Full and empty reports always close their run.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tlast)
    else $error("status result without last");

  // Full and empty reports carry zero data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("status result with nonzero data");

  // A max request answers in the next cycle with a single word.
  a_max_resp: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == REQ_MAX |=> m_tvalid && m_tlast)
    else $error("max request did not answer next cycle");

endmodule

bind bounded_max_queue bmq_checker u_bmq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
